FILE: rtl/srsbd_pkg.sv
package srsbd_pkg;

	localparam logic [7:0] LineFeed = 8'h0A;
	localparam logic [5:0] DigitBias = 6'h30;
	localparam logic [11:0] CountMax = 12'hFFF;

	typedef enum logic [3:0] {
		CMD_BAD     = 4'd0,
		CMD_VV      = 4'd1,
		CMD_PP      = 4'd2,
		CMD_II      = 4'd3,
		CMD_BM      = 4'd4,
		CMD_QT      = 4'd5,
		CMD_RS      = 4'd6,
		CMD_RT      = 4'd7,
		CMD_RB      = 4'd8,
		CMD_GD      = 4'd9,
		CMD_GS      = 4'd10,
		CMD_MD      = 4'd11,
		CMD_MS      = 4'd12,
		CMD_UNKNOWN = 4'd13
	} cmd_class_t;

	typedef enum logic [3:0] {
		ST_00      = 4'd0,
		ST_0L      = 4'd1,
		ST_0M      = 4'd2,
		ST_0E      = 4'd3,
		ST_0F      = 4'd4,
		ST_10      = 4'd5,
		ST_0G      = 4'd6,
		ST_0H      = 4'd7,
		ST_0C      = 4'd8,
		ST_0D      = 4'd9,
		ST_0X      = 4'd10,
		ST_99      = 4'd11,
		ST_UNKNOWN = 4'd12
	} stat_class_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_LINES    = 3'd1,
		ERR_STATUS   = 3'd2,
		ERR_STAMP    = 3'd3,
		ERR_LEFTOVER = 3'd4
	} frame_err_t;

	typedef enum logic {
		KIND_VALUE   = 1'b0,
		KIND_SUMMARY = 1'b1
	} res_kind_t;

	typedef struct packed {
		res_kind_t   kind;
		logic [17:0] distance_value;
		cmd_class_t  command_class;
		stat_class_t status_class;
		frame_err_t  frame_error;
		logic [11:0] value_count;
	} result_t;

	function automatic cmd_class_t cmd_class_f(input logic [15:0] chars, input logic full);
		cmd_class_t c;
		begin
			c = CMD_UNKNOWN;
			case (chars)
				"VV": c = CMD_VV;
				"PP": c = CMD_PP;
				"II": c = CMD_II;
				"BM": c = CMD_BM;
				"QT": c = CMD_QT;
				"RS": c = CMD_RS;
				"RT": c = CMD_RT;
				"RB": c = CMD_RB;
				"GD": c = CMD_GD;
				"GS": c = CMD_GS;
				"MD": c = CMD_MD;
				"MS": c = CMD_MS;
				default: c = CMD_UNKNOWN;
			endcase
			if (!full) begin
				c = CMD_BAD;
			end
			return c;
		end
	endfunction

	function automatic stat_class_t stat_class_f(input logic [15:0] chars, input logic ok);
		stat_class_t s;
		begin
			case (chars)
				"00": s = ST_00;
				"0L": s = ST_0L;
				"0M": s = ST_0M;
				"0E": s = ST_0E;
				"0F": s = ST_0F;
				"10": s = ST_10;
				"0G": s = ST_0G;
				"0H": s = ST_0H;
				"0C": s = ST_0C;
				"0D": s = ST_0D;
				"99": s = ST_99;
				default: begin
					if (chars[15:8] == "0" && chars[7:0] >= "1" && chars[7:0] <= "7") begin
						s = ST_0X;
					end else begin
						s = ST_UNKNOWN;
					end
				end
			endcase
			if (!ok) begin
				s = ST_UNKNOWN;
			end
			return s;
		end
	endfunction

	// digits per value, zero for commands that carry no distances
	function automatic logic [1:0] digits_f(input cmd_class_t c);
		logic [1:0] w;
		begin
			case (c)
				CMD_GD, CMD_MD: w = 2'd3;
				CMD_GS, CMD_MS: w = 2'd2;
				default: w = 2'd0;
			endcase
			return w;
		end
	endfunction

endpackage

FILE: rtl/srsbd_parse.sv
module srsbd_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           byte_in,
	output logic                 res_ready,
	output srsbd_pkg::result_t   res
);

	logic        last_nl_q;
	logic [1:0]  line_idx_q;
	logic [2:0]  line_len_q;
	logic [15:0] cmd_chars_q;
	logic [15:0] stat_chars_q;
	logic        held_valid_q;
	logic [7:0]  held_q;
	logic [17:0] acc_q;
	logic [1:0]  digit_cnt_q;
	logic [11:0] val_cnt_q;
	logic        cmd_full_q;
	logic        stat_ok_q;

	logic        last_nl_d;
	logic [1:0]  line_idx_d;
	logic [2:0]  line_len_d;
	logic [15:0] cmd_chars_d;
	logic [15:0] stat_chars_d;
	logic        held_valid_d;
	logic [7:0]  held_d;
	logic [17:0] acc_d;
	logic [1:0]  digit_cnt_d;
	logic [11:0] val_cnt_d;
	logic        cmd_full_d;
	logic        stat_ok_d;

	srsbd_pkg::cmd_class_t  cmd_c;
	srsbd_pkg::stat_class_t stat_c;
	logic [1:0]  width_c;
	logic        is_lf;
	logic [5:0]  digit;
	logic [17:0] acc_next;
	logic [2:0]  cnt_next;
	logic [11:0] cnt_sat;

	assign cmd_c    = srsbd_pkg::cmd_class_f(cmd_chars_q, cmd_full_q);
	assign stat_c   = srsbd_pkg::stat_class_f(stat_chars_q, stat_ok_q);
	assign width_c  = srsbd_pkg::digits_f(cmd_c);
	assign is_lf    = byte_in == srsbd_pkg::LineFeed;
	assign digit    = held_q[5:0] - srsbd_pkg::DigitBias;
	assign acc_next = {acc_q[11:0], digit};
	assign cnt_next = {1'b0, digit_cnt_q} + 3'd1;
	assign cnt_sat  = (val_cnt_q == srsbd_pkg::CountMax) ? val_cnt_q : val_cnt_q + 12'd1;

	always_comb begin
		last_nl_d    = last_nl_q;
		line_idx_d   = line_idx_q;
		line_len_d   = line_len_q;
		cmd_chars_d  = cmd_chars_q;
		stat_chars_d = stat_chars_q;
		held_valid_d = held_valid_q;
		held_d       = held_q;
		acc_d        = acc_q;
		digit_cnt_d  = digit_cnt_q;
		val_cnt_d    = val_cnt_q;
		cmd_full_d   = cmd_full_q;
		stat_ok_d    = stat_ok_q;
		res_ready    = 1'b0;
		res.kind           = srsbd_pkg::KIND_VALUE;
		res.distance_value = 18'd0;
		res.command_class  = cmd_c;
		res.status_class   = stat_c;
		res.frame_error    = srsbd_pkg::ERR_NONE;
		res.value_count    = val_cnt_q;

		if (is_lf && last_nl_q) begin
			// double line feed closes the frame
			res_ready = 1'b1;
			res.kind  = srsbd_pkg::KIND_SUMMARY;
			if (line_idx_q < 2'd2) begin
				res.frame_error = srsbd_pkg::ERR_LINES;
			end else if (!stat_ok_q) begin
				res.frame_error = srsbd_pkg::ERR_STATUS;
			end else if (width_c != 2'd0 && line_idx_q < 2'd3) begin
				res.frame_error = srsbd_pkg::ERR_STAMP;
			end else if (width_c != 2'd0 && digit_cnt_q != 2'd0) begin
				res.frame_error = srsbd_pkg::ERR_LEFTOVER;
			end
			last_nl_d    = 1'b0;
			line_idx_d   = 2'd0;
			line_len_d   = 3'd0;
			cmd_chars_d  = 16'd0;
			stat_chars_d = 16'd0;
			held_valid_d = 1'b0;
			held_d       = 8'd0;
			acc_d        = 18'd0;
			digit_cnt_d  = 2'd0;
			val_cnt_d    = 12'd0;
			cmd_full_d   = 1'b0;
			stat_ok_d    = 1'b0;
		end else if (is_lf) begin
			if (line_idx_q == 2'd0) begin
				cmd_full_d = line_len_q >= 3'd2;
			end else if (line_idx_q == 2'd1) begin
				stat_ok_d = line_len_q == 3'd3;
			end
			held_valid_d = 1'b0;
			if (line_idx_q != 2'd3) begin
				line_idx_d = line_idx_q + 2'd1;
			end
			line_len_d = 3'd0;
			last_nl_d  = 1'b1;
		end else begin
			last_nl_d = 1'b0;
			if (line_idx_q == 2'd0 && line_len_q == 3'd0) begin
				cmd_chars_d[15:8] = byte_in;
			end
			if (line_idx_q == 2'd0 && line_len_q == 3'd1) begin
				cmd_chars_d[7:0] = byte_in;
			end
			if (line_idx_q == 2'd1 && line_len_q == 3'd0) begin
				stat_chars_d[15:8] = byte_in;
			end
			if (line_idx_q == 2'd1 && line_len_q == 3'd1) begin
				stat_chars_d[7:0] = byte_in;
			end
			if (line_len_q < 3'd4) begin
				line_len_d = line_len_q + 3'd1;
			end
			// one char is held back so the check char at line end is dropped
			if (line_idx_q == 2'd3 && width_c != 2'd0 && stat_ok_q) begin
				held_d       = byte_in;
				held_valid_d = 1'b1;
				if (held_valid_q) begin
					acc_d       = acc_next;
					digit_cnt_d = cnt_next[1:0];
					if (cnt_next >= {1'b0, width_c}) begin
						acc_d       = 18'd0;
						digit_cnt_d = 2'd0;
						val_cnt_d   = cnt_sat;
						res_ready   = 1'b1;
						res.distance_value = acc_next;
						res.value_count    = cnt_sat;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_nl_q    <= 1'b0;
			line_idx_q   <= 2'd0;
			line_len_q   <= 3'd0;
			cmd_chars_q  <= 16'd0;
			stat_chars_q <= 16'd0;
			held_valid_q <= 1'b0;
			held_q       <= 8'd0;
			acc_q        <= 18'd0;
			digit_cnt_q  <= 2'd0;
			val_cnt_q    <= 12'd0;
			cmd_full_q   <= 1'b0;
			stat_ok_q    <= 1'b0;
		end else if (step) begin
			last_nl_q    <= last_nl_d;
			line_idx_q   <= line_idx_d;
			line_len_q   <= line_len_d;
			cmd_chars_q  <= cmd_chars_d;
			stat_chars_q <= stat_chars_d;
			held_valid_q <= held_valid_d;
			held_q       <= held_d;
			acc_q        <= acc_d;
			digit_cnt_q  <= digit_cnt_d;
			val_cnt_q    <= val_cnt_d;
			cmd_full_q   <= cmd_full_d;
			stat_ok_q    <= stat_ok_d;
		end
	end

endmodule

FILE: rtl/srsbd_out.sv
module srsbd_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  srsbd_pkg::result_t   res_in,
	input  logic                 stall,
	output logic                 free,
	output logic                 valid,
	output srsbd_pkg::result_t   res_out
);

	logic               valid_q;
	srsbd_pkg::result_t res_q;

	// the register can take a new result when empty or being drained
	assign free    = !valid_q || !stall;
	assign valid   = valid_q;
	assign res_out = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res_in;
		end
	end

endmodule

FILE: rtl/scan_response_six_bit_decoder_core.sv
// scanner reply decoder
// input channel: rx_byte with rx_valid / rx_stall, one reply byte per item
// output channel: res_valid / res_stall with kind, distance_value,
//   command_class, status_class, frame_error and value_count
// each byte gives zero or one result: a decoded distance value (kind 0) as
// soon as its last digit is known, or a frame summary (kind 1) on the
// second of two line feeds
// a byte is taken into an input register and decoded from there in the
// following cycle; its result is loaded into the output register once that
// register is free, and res_valid rises with that load
// throughput: one byte per cycle while res_stall is low; bytes that give
// no result keep flowing even while a result waits to be taken
// when res_stall holds a result, the next result-producing byte waits in
// the input register and rx_stall rises once that register is blocked
// reset clears the frame state and the valid flags of both registers; the first byte after
// reset starts line 0 of a new frame
module scan_response_six_bit_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        kind,
	output logic [17:0] distance_value,
	output logic [3:0]  command_class,
	output logic [3:0]  status_class,
	output logic [2:0]  frame_error,
	output logic [11:0] value_count
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               produces;
	logic               out_free;
	logic               advance;
	srsbd_pkg::result_t res_c;
	srsbd_pkg::result_t res_o;

	assign advance  = valid_s1 && (!produces || out_free);
	assign rx_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	srsbd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in   (byte_s1),
		.res_ready (produces),
		.res       (res_c)
	);

	srsbd_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && produces),
		.res_in  (res_c),
		.stall   (res_stall),
		.free    (out_free),
		.valid   (res_valid),
		.res_out (res_o)
	);

	assign kind           = res_o.kind;
	assign distance_value = res_o.distance_value;
	assign command_class  = res_o.command_class;
	assign status_class   = res_o.status_class;
	assign frame_error    = res_o.frame_error;
	assign value_count    = res_o.value_count;

	a_summary_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_o.kind == srsbd_pkg::KIND_SUMMARY |-> distance_value == 18'd0)
		else $error("summary carries a distance value");

	a_value_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_o.kind == srsbd_pkg::KIND_VALUE
			|-> res_o.frame_error == srsbd_pkg::ERR_NONE)
		else $error("value item carries a frame error");

	a_value_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_o.kind == srsbd_pkg::KIND_VALUE |-> value_count != 12'd0)
		else $error("value item with zero count");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("blocked input register lost its byte");

endmodule

FILE: test/scan_response_six_bit_decoder_core_test.sv
module scan_response_six_bit_decoder_core_test;

	typedef struct {
		srsbd_pkg::res_kind_t   kind;
		logic [17:0]            value;
		srsbd_pkg::cmd_class_t  cmd;
		srsbd_pkg::stat_class_t stat;
		srsbd_pkg::frame_err_t  err;
		logic [11:0]            count;
	} reply_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        kind;
	logic [17:0] distance_value;
	logic [3:0]  command_class;
	logic [3:0]  status_class;
	logic [2:0]  frame_error;
	logic [11:0] value_count;

	scan_response_six_bit_decoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(kind),
		.distance_value(distance_value),
		.command_class(command_class),
		.status_class(status_class),
		.frame_error(frame_error),
		.value_count(value_count)
	);

	initial forever #6 clk = ~clk;

	initial begin
		#12_000_000;
		$display("[scan_response_six_bit_decoder_core] ERROR");
		$finish;
	end

	// decoded results still owed by the block, oldest first
	reply_result_t reply_results[$];
	logic [7:0] frame_bytes[$];

	logic [15:0] command_words [12] = '{"VV", "PP", "II", "BM", "QT", "RS",
		"RT", "RB", "GD", "GS", "MD", "MS"};
	logic [15:0] status_words [13] = '{"00", "0L", "0M", "0E", "0F", "10",
		"0G", "0H", "0C", "0D", "01", "99", "??"};

	// reply decoder state
	bit          at_lf;
	int          line_no;
	int          line_len;
	logic [7:0]  cmd_pair [2];
	logic [7:0]  stat_pair [2];
	bit          cmd_long;
	bit          stat_exact;
	bit          held_ok;
	logic [7:0]  held_byte;
	logic [17:0] acc;
	int          digits_held;
	logic [11:0] frame_values;

	bit steady;
	int hold_left;
	int mismatches;
	int bytes_sent;
	int frames_sent;
	int values_checked;
	int summaries_checked;

	task automatic clear_reply_frame();
		at_lf = 1'b0;
		line_no = 0;
		line_len = 0;
		cmd_pair = '{8'h00, 8'h00};
		stat_pair = '{8'h00, 8'h00};
		cmd_long = 1'b0;
		stat_exact = 1'b0;
		held_ok = 1'b0;
		held_byte = 8'h00;
		acc = '0;
		digits_held = 0;
		frame_values = '0;
	endtask

	function automatic srsbd_pkg::cmd_class_t command_now();
		srsbd_pkg::cmd_class_t c;
		case ({cmd_pair[0], cmd_pair[1]})
			"VV": c = srsbd_pkg::CMD_VV;
			"PP": c = srsbd_pkg::CMD_PP;
			"II": c = srsbd_pkg::CMD_II;
			"BM": c = srsbd_pkg::CMD_BM;
			"QT": c = srsbd_pkg::CMD_QT;
			"RS": c = srsbd_pkg::CMD_RS;
			"RT": c = srsbd_pkg::CMD_RT;
			"RB": c = srsbd_pkg::CMD_RB;
			"GD": c = srsbd_pkg::CMD_GD;
			"GS": c = srsbd_pkg::CMD_GS;
			"MD": c = srsbd_pkg::CMD_MD;
			"MS": c = srsbd_pkg::CMD_MS;
			default: c = srsbd_pkg::CMD_UNKNOWN;
		endcase
		return cmd_long ? c : srsbd_pkg::CMD_BAD;
	endfunction

	function automatic srsbd_pkg::stat_class_t status_now();
		srsbd_pkg::stat_class_t s;
		case ({stat_pair[0], stat_pair[1]})
			"00": s = srsbd_pkg::ST_00;
			"0L": s = srsbd_pkg::ST_0L;
			"0M": s = srsbd_pkg::ST_0M;
			"0E": s = srsbd_pkg::ST_0E;
			"0F": s = srsbd_pkg::ST_0F;
			"10": s = srsbd_pkg::ST_10;
			"0G": s = srsbd_pkg::ST_0G;
			"0H": s = srsbd_pkg::ST_0H;
			"0C": s = srsbd_pkg::ST_0C;
			"0D": s = srsbd_pkg::ST_0D;
			"99": s = srsbd_pkg::ST_99;
			default: begin
				if (stat_pair[0] == "0" && stat_pair[1] >= "1" && stat_pair[1] <= "7") begin
					s = srsbd_pkg::ST_0X;
				end else begin
					s = srsbd_pkg::ST_UNKNOWN;
				end
			end
		endcase
		return stat_exact ? s : srsbd_pkg::ST_UNKNOWN;
	endfunction

	function automatic int digits_per_value(input srsbd_pkg::cmd_class_t c);
		case (c)
			srsbd_pkg::CMD_GD, srsbd_pkg::CMD_MD: return 3;
			srsbd_pkg::CMD_GS, srsbd_pkg::CMD_MS: return 2;
			default: return 0;
		endcase
	endfunction

	task automatic decode_reply_byte(input logic [7:0] b);
		reply_result_t r;
		int width;
		bit had;
		logic [5:0] digit;
		width = digits_per_value(command_now());
		r.value = '0;
		r.err = srsbd_pkg::ERR_NONE;
		if (b == srsbd_pkg::LineFeed && at_lf) begin
			if (line_no < 2) begin
				r.err = srsbd_pkg::ERR_LINES;
			end else if (!stat_exact) begin
				r.err = srsbd_pkg::ERR_STATUS;
			end else if (width != 0 && line_no < 3) begin
				r.err = srsbd_pkg::ERR_STAMP;
			end else if (width != 0 && digits_held != 0) begin
				r.err = srsbd_pkg::ERR_LEFTOVER;
			end
			r.kind = srsbd_pkg::KIND_SUMMARY;
			r.cmd = command_now();
			r.stat = status_now();
			r.count = frame_values;
			reply_results.push_back(r);
			clear_reply_frame();
		end else if (b == srsbd_pkg::LineFeed) begin
			if (line_no == 0) begin
				cmd_long = line_len >= 2;
			end else if (line_no == 1) begin
				stat_exact = line_len == 3;
			end
			held_ok = 1'b0;
			if (line_no < 3) begin
				line_no++;
			end
			line_len = 0;
			at_lf = 1'b1;
		end else begin
			at_lf = 1'b0;
			if (line_len < 2 && line_no == 0) begin
				cmd_pair[line_len] = b;
			end else if (line_len < 2 && line_no == 1) begin
				stat_pair[line_len] = b;
			end
			if (line_len < 4) begin
				line_len++;
			end
			// the newest char of a data line may be its check char, so decode one behind
			if (line_no == 3 && width != 0 && stat_exact) begin
				had = held_ok;
				digit = held_byte[5:0] - srsbd_pkg::DigitBias;
				held_byte = b;
				held_ok = 1'b1;
				if (had) begin
					acc = {acc[11:0], digit};
					digits_held++;
					if (digits_held >= width) begin
						r.kind = srsbd_pkg::KIND_VALUE;
						r.value = acc;
						acc = '0;
						digits_held = 0;
						if (frame_values < srsbd_pkg::CountMax) begin
							frame_values++;
						end
						r.cmd = command_now();
						r.stat = status_now();
						r.count = frame_values;
						reply_results.push_back(r);
					end
				end
			end
		end
	endtask

	function automatic int pick_pause();
		int r;
		r = $urandom_range(99, 0);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(30, 8);
	endfunction

	function automatic logic [7:0] random_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255, 0)); while (c == srsbd_pkg::LineFeed);
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40) begin
			$display("mismatch on %s: got %0h, want %0h (result %0d)", what, got, want,
				values_checked + summaries_checked);
		end
		mismatches++;
	endtask

	// result side: check every accepted result, stall at random
	always @(posedge clk) begin : result_monitor
		reply_result_t want;
		if (res_valid && !res_stall) begin
			if (reply_results.size() == 0) begin
				report_mismatch("result with nothing owed", 32'(kind), 32'd0);
			end else begin
				want = reply_results.pop_front();
				if (kind !== want.kind) begin
					report_mismatch("kind", 32'(kind), 32'(want.kind));
				end
				if (distance_value !== want.value) begin
					report_mismatch("distance_value", 32'(distance_value), 32'(want.value));
				end
				if (command_class !== want.cmd) begin
					report_mismatch("command_class", 32'(command_class), 32'(want.cmd));
				end
				if (status_class !== want.stat) begin
					report_mismatch("status_class", 32'(status_class), 32'(want.stat));
				end
				if (frame_error !== want.err) begin
					report_mismatch("frame_error", 32'(frame_error), 32'(want.err));
				end
				if (value_count !== want.count) begin
					report_mismatch("value_count", 32'(value_count), 32'(want.count));
				end
				if (want.kind == srsbd_pkg::KIND_SUMMARY) summaries_checked++;
				else values_checked++;
			end
		end
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= 1'b0;
			if (!steady && $urandom_range(2, 0) == 0) hold_left = pick_pause();
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int pause;
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		decode_reply_byte(b);
		bytes_sent++;
		pause = steady ? 0 : pick_pause();
		if (pause > 0) begin
			rx_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
	endtask

	task automatic send_frame_bytes();
		foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
		frames_sent++;
	endtask

	// line feeds until a fresh frame starts
	task automatic settle_frame();
		while (at_lf || line_no != 0 || line_len != 0) send_byte(srsbd_pkg::LineFeed);
	endtask

	task automatic wait_for_results();
		rx_valid <= 1'b0;
		while (reply_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
	endtask

	task automatic push_chars(input int n);
		repeat (n) frame_bytes.push_back(random_char());
	endtask

	task automatic build_reply_frame();
		int pick;
		int n;
		logic [15:0] w;
		frame_bytes.delete();
		pick = $urandom_range(99, 0);
		if (pick < 60) begin
			w = command_words[8 + $urandom_range(3, 0)];
		end else begin
			w = command_words[$urandom_range(7, 0)];
		end
		if (pick < 80) begin
			frame_bytes.push_back(w[15:8]);
			frame_bytes.push_back(w[7:0]);
		end else if (pick < 90) begin
			push_chars(2);
		end else begin
			push_chars($urandom_range(1, 0));
		end
		if ($urandom_range(4, 0) == 0) push_chars($urandom_range(3, 1));
		frame_bytes.push_back(srsbd_pkg::LineFeed);
		if ($urandom_range(99, 0) < 85) begin
			n = $urandom_range(12, 0);
			w = status_words[n];
			if (n == 10) w[7:0] = 8'("1" + $urandom_range(6, 0));
			if (n == 12) w = {random_char(), random_char()};
			frame_bytes.push_back(w[15:8]);
			frame_bytes.push_back(w[7:0]);
			push_chars(1);
		end else begin
			n = $urandom_range(5, 1);
			push_chars(n >= 3 ? n + 1 : n);
		end
		frame_bytes.push_back(srsbd_pkg::LineFeed);
		// now and then the time stamp and data are missing
		if ($urandom_range(9, 0) != 0) begin
			push_chars($urandom_range(5, 1));
			frame_bytes.push_back(srsbd_pkg::LineFeed);
			repeat ($urandom_range(4, 1)) begin
				push_chars($urandom_range(6, 0) == 0 ? $urandom_range(90, 25)
					: $urandom_range(24, 1));
				frame_bytes.push_back(srsbd_pkg::LineFeed);
			end
		end
		frame_bytes.push_back(srsbd_pkg::LineFeed);
	endtask

	task automatic test_short_frames();
		frame_bytes.delete();
		// empty frame, then a third line feed that ends an empty line 0
		push_text("\n\n\n");
		frame_bytes.push_back(8'h00);
		push_text("\n\nGD\n00P\n\n");
		send_frame_bytes();
	endtask

	task automatic test_value_extremes();
		frame_bytes.delete();
		push_text("MS\n99x\nT\n");
		frame_bytes.push_back(8'h00);
		frame_bytes.push_back(8'hFF);
		frame_bytes.push_back(8'h30);
		push_text("\n\n");
		send_frame_bytes();
		wait_for_results();
	endtask

	task automatic test_random_replies();
		int start;
		int pick;
		int n;
		start = bytes_sent;
		while (bytes_sent - start < 1750) begin
			steady = $urandom_range(5, 0) == 0;
			pick = $urandom_range(99, 0);
			if (pick < 80) begin
				build_reply_frame();
			end else if (pick < 92) begin
				frame_bytes.delete();
				repeat ($urandom_range(16, 1)) begin
					frame_bytes.push_back($urandom_range(2, 0) == 0 ? srsbd_pkg::LineFeed
						: random_char());
				end
			end else begin
				build_reply_frame();
				n = $urandom_range(frame_bytes.size() - 1, 1);
				while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
			end
			send_frame_bytes();
			settle_frame();
			if (frames_sent % 40 == 0) wait_for_results();
		end
		steady = 1'b0;
		wait_for_results();
	endtask

	initial begin
		clear_reply_frame();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_frames();
		test_value_extremes();
		test_random_replies();
		wait_for_results();
		repeat (10) @(posedge clk);
		$display("sent %0d reply bytes in %0d frames (empty, noisy, cut short)",
			bytes_sent, frames_sent);
		$display("checked %0d distance values and %0d frame summaries field by field",
			values_checked, summaries_checked);
		if (mismatches == 0) begin
			$display("[scan_response_six_bit_decoder_core] OK");
		end else begin
			$display("[scan_response_six_bit_decoder_core] ERROR");
		end
		$finish;
	end

endmodule
